// ===== hw/rtl/bdps_pkg.sv =====
// ----------------------------------------------------------------------------
// bdps_pkg
// Shared sizes, codes and helper functions of the banded dfa pattern scanner.
// ----------------------------------------------------------------------------
package bdps_pkg;

   // table sizes
   localparam int STATE_COUNT = 4096;
   localparam int BAND_WORDS  = 65536;
   localparam int MAX_BUFFER  = 65536;

   // field widths
   localparam int STATE_W   = 12;
   localparam int POS_W     = 17;
   localparam int WORD_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int BADDR_W   = 17;
   localparam int STATE_AW  = $clog2(STATE_COUNT);
   localparam int BAND_AW   = $clog2(BAND_WORDS);

   // position saturates at the buffer size or at the field maximum
   localparam int POS_MAX   = (1 << POS_W) - 1;
   localparam int POS_LIMIT = (MAX_BUFFER > POS_MAX) ? POS_MAX : MAX_BUFFER;

   // row layout: offsets of the words inside a row
   localparam logic [BADDR_W-1:0] ROW_MATCH_OFS = BADDR_W'(1);
   localparam logic [BADDR_W-1:0] ROW_COUNT_OFS = BADDR_W'(2);
   localparam logic [BADDR_W-1:0] ROW_FIRST_OFS = BADDR_W'(3);
   localparam logic [BADDR_W-1:0] ROW_ENTRY_OFS = BADDR_W'(4);

   // stream payload widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [1:0] {
      OP_WRITE_ROW  = 2'd0,
      OP_WRITE_BAND = 2'd1,
      OP_SCAN       = 2'd2,
      OP_SET_STATE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DISPATCH,
      ST_ENTRY,
      ST_NEXT,
      ST_BASE,
      ST_HDR
   } seq_type;

   // ascii lower case to upper case
   function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // states outside the table fall back to the root
   function automatic logic [STATE_W-1:0] legal_state(input logic [WORD_W-1:0] s);
      logic [STATE_W-1:0] r;
      r = '0;
      if ({16'd0, s} < STATE_COUNT && {16'd0, s} <= ((1 << STATE_W) - 1)) begin
         r = s[STATE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/banded_dfa_pattern_scan_unit.sv =====
// ----------------------------------------------------------------------------
// banded_dfa_pattern_scan_unit
// Aho-Corasick scanner that walks a banded transition table held in on-chip
// row pointer and band word memories.
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one command per transfer, selected by req_tuser:
//   write a row pointer, write a band word, scan a text byte, or set the
//   current state. req_tlast marks the last byte of a buffer and restarts the
//   byte position after it.
//   rsp channel carries one transfer for each scanned byte that enters an
//   accepting state: the state and the end position inside the buffer.
// timing:
//   a one-entry input register takes a new transfer while the previous one
//   is still being worked on. writes and set-state are done in the dispatch
//   state. a scan byte walks the dependent memory reads of a byte in order:
//   band entry, row pointer of the next state, band header of that row. after
//   reset, a write or set-state the current state's band header is not held
//   in registers and is fetched again before the band entry is read. a result
//   is loaded into the output register in the dispatch state that follows the
//   read of the new state's match word.
// reset and stall:
//   reset returns to the root state with position zero; the tables are not
//   cleared and must be loaded before scanning. a result waits in the output
//   register while rsp_tready is low; the next byte is still taken and
//   processed, and the block holds only when a second result is ready.
// ----------------------------------------------------------------------------
module banded_dfa_pattern_scan_unit
   import bdps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // addr[15:0], data[31:16], byte_value[39:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // match_state[11:0], end_position[28:12], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);

   // memories
   logic [WORD_W-1:0] row_mem  [STATE_COUNT];
   logic [WORD_W-1:0] band_mem [BAND_WORDS];

   // sequencer
   seq_type state_ff, state_in;

   // input register
   logic               in_valid_ff, in_valid_in;
   op_type             in_op_ff;
   logic [WORD_W-1:0]  in_addr_ff, in_data_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;

   // scan state and cached header of the current state
   logic [STATE_W-1:0] scan_state_ff, scan_state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;
   logic [WORD_W-1:0]  base_ff, base_in;
   logic [WORD_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0]  first_ff, first_in;
   logic               info_valid_ff, info_valid_in;
   logic               fetch_ff, fetch_in;
   logic               match_pending_ff, match_pending_in;
   logic               inband_ff, inband_in;
   logic               last_ff, last_in;

   // memory read data
   logic [WORD_W-1:0]  row_rd_ff;
   logic [WORD_W-1:0]  rd0_data_ff, rd1_data_ff;
   logic               rd0_ok_ff, rd1_ok_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_state_ff;
   logic [POS_W-1:0]   rsp_pos_ff;

   // control
   logic               accept, consume, entry_go, fetch_go, stall, hit, rsp_load;
   logic               row_we, row_re, band_we, b0_re, b1_re;
   logic [STATE_W-1:0] row_ra;
   logic [BADDR_W-1:0] b0_addr, b1_addr;

   // entry lookup of the byte in the current band
   logic [BYTE_W-1:0]  up_byte;
   logic [BADDR_W-1:0] c_ext, first_ext, band_end, ent_addr;
   logic               ent_inband;
   logic [STATE_W-1:0] step_state;
   logic [POS_W-1:0]   pos_inc;

   // band lookup arithmetic
   always_comb begin
      up_byte    = upcase(in_byte_ff);
      c_ext      = {{(BADDR_W-BYTE_W){1'b0}}, up_byte};
      first_ext  = {1'b0, first_ff};
      band_end   = first_ext + {1'b0, count_ff};
      ent_inband = (c_ext >= first_ext) && (c_ext < band_end);
      ent_addr   = {1'b0, base_ff} + ROW_ENTRY_OFS + (c_ext - first_ext);
      step_state = (inband_ff && rd1_ok_ff) ? legal_state(rd1_data_ff) : '0;
      pos_inc    = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
   end

   // pending match from the band read of the previous byte
   assign hit   = match_pending_ff && rd0_ok_ff && (rd0_data_ff != '0);
   assign stall = hit && rsp_valid_ff && !rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_DISPATCH: begin
            if (!stall && in_valid_ff && in_op_ff == OP_SCAN) begin
               state_in = info_valid_ff ? ST_NEXT : ST_BASE;
            end
         end
         ST_ENTRY: state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_BASE;
         ST_BASE:  state_in = ST_HDR;
         ST_HDR:   state_in = fetch_ff ? ST_ENTRY : ST_DISPATCH;
         default:  state_in = ST_DISPATCH;
      endcase
   end

   // control outputs and memory ports
   always_comb begin
      consume  = 1'b0;
      entry_go = 1'b0;
      fetch_go = 1'b0;
      rsp_load = 1'b0;
      row_we   = 1'b0;
      band_we  = 1'b0;
      row_re   = 1'b0;
      row_ra   = scan_state_ff;
      b0_re    = 1'b0;
      b0_addr  = '0;
      b1_re    = 1'b0;
      b1_addr  = ent_addr;
      case (state_ff)
         ST_DISPATCH: begin
            if (!stall) begin
               rsp_load = hit;
               if (in_valid_ff) begin
                  case (in_op_ff)
                     OP_WRITE_ROW: begin
                        consume = 1'b1;
                        row_we  = {16'd0, in_addr_ff} < STATE_COUNT;
                     end
                     OP_WRITE_BAND: begin
                        consume = 1'b1;
                        band_we = {16'd0, in_addr_ff} < BAND_WORDS;
                     end
                     OP_SET_STATE: consume = 1'b1;
                     OP_SCAN: begin
                        if (info_valid_ff) begin
                           consume  = 1'b1;
                           entry_go = 1'b1;
                        end else begin
                           fetch_go = 1'b1;
                           row_re   = 1'b1;
                           row_ra   = scan_state_ff;
                        end
                     end
                     default: consume = 1'b1;
                  endcase
               end
            end
         end
         ST_ENTRY: begin
            consume  = 1'b1;
            entry_go = 1'b1;
         end
         ST_NEXT: begin
            row_re = 1'b1;
            row_ra = step_state;
         end
         ST_BASE: begin
            b0_re   = 1'b1;
            b0_addr = {1'b0, row_rd_ff} + ROW_COUNT_OFS;
            b1_re   = 1'b1;
            b1_addr = {1'b0, row_rd_ff} + ROW_FIRST_OFS;
         end
         ST_HDR: begin
            b0_re   = !fetch_ff;
            b0_addr = {1'b0, base_ff} + ROW_MATCH_OFS;
         end
         default: begin
            consume = 1'b0;
         end
      endcase
      if (entry_go) begin
         b1_re   = ent_inband;
         b1_addr = ent_addr;
      end
   end

   // input register handshake
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   // next values of the datapath registers
   always_comb begin
      in_valid_in      = accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      scan_state_in    = scan_state_ff;
      pos_in           = pos_ff;
      res_pos_in       = res_pos_ff;
      base_in          = base_ff;
      count_in         = count_ff;
      first_in         = first_ff;
      info_valid_in    = info_valid_ff;
      fetch_in         = fetch_ff;
      match_pending_in = match_pending_ff;
      inband_in        = inband_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      // match resolved in the dispatch cycle
      if (state_ff == ST_DISPATCH && !stall) begin
         match_pending_in = 1'b0;
      end
      // writes and state changes drop the cached header
      if (consume && !entry_go) begin
         info_valid_in = 1'b0;
         if (in_op_ff == OP_SET_STATE) begin
            scan_state_in = legal_state(in_data_ff);
         end
      end
      if (fetch_go) begin
         fetch_in = 1'b1;
      end
      if (entry_go) begin
         inband_in = ent_inband;
         last_in   = in_last_ff;
      end
      // step to the next state and count the byte
      if (state_ff == ST_NEXT) begin
         scan_state_in = step_state;
         res_pos_in    = pos_inc;
         pos_in        = last_ff ? '0 : pos_inc;
      end
      if (state_ff == ST_BASE) begin
         base_in = row_rd_ff;
      end
      // band header of the new current state
      if (state_ff == ST_HDR) begin
         count_in         = rd0_ok_ff ? rd0_data_ff : '0;
         first_in         = rd1_ok_ff ? rd1_data_ff : '0;
         info_valid_in    = 1'b1;
         fetch_in         = 1'b0;
         match_pending_in = !fetch_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_DISPATCH;
         in_valid_ff      <= 1'b0;
         scan_state_ff    <= '0;
         pos_ff           <= '0;
         info_valid_ff    <= 1'b0;
         fetch_ff         <= 1'b0;
         match_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         in_valid_ff      <= in_valid_in;
         scan_state_ff    <= scan_state_in;
         pos_ff           <= pos_in;
         info_valid_ff    <= info_valid_in;
         fetch_ff         <= fetch_in;
         match_pending_ff <= match_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= op_type'(req_tuser);
         in_addr_ff <= req_tdata[15:0];
         in_data_ff <= req_tdata[31:16];
         in_byte_ff <= req_tdata[39:32];
         in_last_ff <= req_tlast;
      end
      res_pos_ff <= res_pos_in;
      base_ff    <= base_in;
      count_ff   <= count_in;
      first_ff   <= first_in;
      inband_ff  <= inband_in;
      last_ff    <= last_in;
      if (rsp_load) begin
         rsp_state_ff <= scan_state_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   // row pointer memory
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[in_addr_ff[STATE_AW-1:0]] <= in_data_ff;
      end
      if (row_re) begin
         row_rd_ff <= row_mem[row_ra[STATE_AW-1:0]];
      end
   end

   // band word memory, one write and two read ports
   always_ff @(posedge clock) begin
      if (band_we) begin
         band_mem[in_addr_ff[BAND_AW-1:0]] <= in_data_ff;
      end
      if (b0_re) begin
         rd0_data_ff <= band_mem[b0_addr[BAND_AW-1:0]];
         rd0_ok_ff   <= b0_addr < BAND_WORDS;
      end
      if (b1_re) begin
         rd1_data_ff <= band_mem[b1_addr[BAND_AW-1:0]];
         rd1_ok_ff   <= b1_addr < BAND_WORDS;
      end
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-STATE_W-POS_W){1'b0}}, rsp_pos_ff, rsp_state_ff};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the banded dfa pattern scanner. Transition tables are loaded through
// write transfers, text bytes are streamed on the req channel, and every rsp
// transfer is compared against a local copy of the scanner state held in this
// file. Covers fixed corner rows, position count and buffer restart, and
// random automata.
// ----------------------------------------------------------------------------
module testbench
   import bdps_pkg::*;
();

   localparam int POS_SAT     = (MAX_BUFFER < 131071) ? MAX_BUFFER : 131071;
   localparam int STALL_LIMIT = 2000;
   localparam int RUN_LEN     = 16;

   typedef struct packed {
      logic [11:0] state;
      logic [16:0] position;
   } match_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   // addr[15:0], data[31:16], byte_value[39:32]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // op[1:0]
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // match_state[11:0], end_position[28:12], zero fill above
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   // local copy of the tables and scan registers
   logic [15:0] row_mem  [0:STATE_COUNT-1];
   logic [15:0] band_mem [0:BAND_WORDS-1];
   logic [11:0] dfa_state  = '0;
   logic [16:0] byte_count = '0;

   match_type   expected_matches[$];
   logic [11:0] live_states[$];
   logic [15:0] entry_slots[$];
   int unsigned row_cursor   = 32'h100;
   bit          req_idle_en  = 1'b1;
   bit          rsp_idle_en  = 1'b1;
   int          mismatches   = 0;
   int          stall_cycles = 0;

   banded_dfa_pattern_scan_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- scanner copy

   function automatic logic [15:0] band_word(input int unsigned a);
      if (a >= BAND_WORDS) begin
         return 16'h0000;
      end
      return band_mem[a];
   endfunction

   function automatic logic [11:0] clamp_state(input int unsigned s);
      if (s >= STATE_COUNT || s > 12'hFFF) begin
         return 12'd0;
      end
      return s[11:0];
   endfunction

   function automatic int unsigned to_upper_ascii(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // one scanned byte: band lookup, position count, match report
   task automatic scan_byte_model(input logic [7:0] text_byte, input bit last);
      int unsigned base, count, first, c;
      logic [11:0] next_s;
      match_type   hit;
      base  = row_mem[dfa_state];
      count = band_word(base + 2);
      first = band_word(base + 3);
      c     = to_upper_ascii(text_byte);
      if (c < first || c >= first + count) begin
         next_s = 12'd0;
      end else begin
         next_s = clamp_state(band_word(base + 4 + (c - first)));
      end
      dfa_state = next_s;
      if (byte_count < POS_SAT) begin
         byte_count = byte_count + 1'b1;
      end
      if (band_word(row_mem[next_s] + 1) != 16'h0000) begin
         hit.state    = next_s;
         hit.position = byte_count;
         expected_matches.push_back(hit);
      end
      if (last) begin
         byte_count = '0;
      end
   endtask

   task automatic apply_command(input op_type op, input logic [15:0] addr,
                                input logic [15:0] data, input logic [7:0] text_byte,
                                input bit last);
      case (op)
         OP_WRITE_ROW: begin
            if (addr < STATE_COUNT) begin
               row_mem[addr] = data;
            end
         end
         OP_WRITE_BAND: begin
            band_mem[addr] = data;
         end
         OP_SET_STATE: begin
            dfa_state = clamp_state(data);
         end
         OP_SCAN: begin
            scan_byte_model(text_byte, last);
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------- drivers

   // one req transfer, with a random idle gap in front
   task automatic send_item(input op_type op, input logic [15:0] addr,
                            input logic [15:0] data, input logic [7:0] text_byte,
                            input bit last);
      if (req_idle_en && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 34);
      end
      req_tdata  <= {text_byte, data, addr};
      req_tuser  <= op;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_command(op, addr, data, text_byte, last);
   endtask

   // table writes and set-state, unused fields random
   task automatic send_write(input op_type op, input logic [15:0] addr,
                             input logic [15:0] data);
      send_item(op, addr, data, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic send_scan(input logic [7:0] text_byte, input bit last);
      send_item(OP_SCAN, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                text_byte, last);
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
   endtask

   // mostly a byte inside the current band, so scans walk deep into the automaton
   function automatic logic [7:0] steer_byte();
      int unsigned base, count, first, span, c;
      base  = row_mem[dfa_state];
      count = band_word(base + 2);
      first = band_word(base + 3);
      if (count == 0 || first > 255 || $urandom_range(99) < 25) begin
         return 8'($urandom_range(255));
      end
      span = 256 - first;
      if (count < span) begin
         span = count;
      end
      c = first + $urandom_range(span - 1);
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) begin
         c = c + 8'h20;
      end
      return c[7:0];
   endfunction

   // next state for a band entry: a loaded state, or one that falls back to root
   function automatic logic [15:0] pick_target();
      if ($urandom_range(9) < 8) begin
         return {4'd0, live_states[$urandom_range(live_states.size() - 1)]};
      end
      return 16'($urandom_range(16'hFFFF, STATE_COUNT));
   endfunction

   // load a random automaton; every row is complete before any scan
   task automatic build_dfa(input int n_states, input int max_count);
      logic [11:0] states[$];
      int unsigned count, first, pick;
      logic [15:0] match_word;
      states.push_back(12'd0);
      while (states.size() < n_states) begin
         states.push_back(12'($urandom_range(4094, 1)));
      end
      foreach (states[i]) begin
         live_states.push_back(states[i]);
      end
      foreach (states[i]) begin
         count = ($urandom_range(9) == 0) ? 0 : $urandom_range(max_count, 1);
         pick  = $urandom_range(9);
         if (pick < 6) begin
            first = 8'h41 + $urandom_range(25);
         end else if (pick < 9) begin
            first = $urandom_range(255);
         end else begin
            first = $urandom_range(16'hFFFF, 256);
         end
         match_word = ($urandom_range(2) == 0) ? 16'($urandom_range(16'hFFFF, 1)) : 16'h0;
         send_write(OP_WRITE_ROW, {4'd0, states[i]}, row_cursor[15:0]);
         send_write(OP_WRITE_BAND, row_cursor[15:0], 16'($urandom_range(16'hFFFF)));
         send_write(OP_WRITE_BAND, 16'(row_cursor + 1), match_word);
         send_write(OP_WRITE_BAND, 16'(row_cursor + 2), count[15:0]);
         send_write(OP_WRITE_BAND, 16'(row_cursor + 3), first[15:0]);
         for (int k = 0; k < count; k++) begin
            entry_slots.push_back(16'(row_cursor + 4 + k));
            send_write(OP_WRITE_BAND, 16'(row_cursor + 4 + k), pick_target());
         end
         row_cursor = row_cursor + 4 + count;
      end
   endtask

   // mixed traffic, mostly scans that follow the bands
   task automatic random_traffic(input int n_items);
      int unsigned r;
      logic [15:0] value;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) begin
            pause_until_drained();
         end
         r = $urandom_range(99);
         if (r < 70) begin
            send_scan(steer_byte(), $urandom_range(19) == 0);
         end else if (r < 78) begin
            send_scan(8'($urandom_range(255)), $urandom_range(19) == 0);
         end else if (r < 84) begin
            value = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF, STATE_COUNT))
                                             : {4'd0, live_states[$urandom_range(
                                                live_states.size() - 1)]};
            send_write(OP_SET_STATE, 16'($urandom_range(16'hFFFF)), value);
         end else if (r < 89) begin
            send_write(OP_WRITE_BAND, entry_slots[$urandom_range(entry_slots.size() - 1)],
                       pick_target());
         end else if (r < 94) begin
            // point a state at the row of another loaded state
            value = row_mem[live_states[$urandom_range(live_states.size() - 1)]];
            send_write(OP_WRITE_ROW,
                       {4'd0, live_states[$urandom_range(live_states.size() - 1)]}, value);
         end else if (r < 97) begin
            // state index out of range, ignored
            send_write(OP_WRITE_ROW, 16'($urandom_range(16'hFFFF, STATE_COUNT)),
                       16'($urandom_range(16'hFFFF)));
         end else begin
            // words outside every live band, or the top match word
            value = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFFFE))
                                             : 16'($urandom_range(16'hFFF0, 16'h1000));
            send_write(OP_WRITE_BAND, value, 16'($urandom_range(16'hFFFF)));
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // fixed rows: band edges, case folding, fallback states, rows at the top of memory
   task automatic test_directed_lookup();
      // root row at 0x10: band 'A'..'B', 'A' to state 4095, 'B' to an illegal state
      send_write(OP_WRITE_ROW, 16'd0, 16'h0010);
      send_write(OP_WRITE_BAND, 16'h0010, 16'hA5A5);
      send_write(OP_WRITE_BAND, 16'h0011, 16'h0000);
      send_write(OP_WRITE_BAND, 16'h0012, 16'h0002);
      send_write(OP_WRITE_BAND, 16'h0013, 16'h0041);
      send_write(OP_WRITE_BAND, 16'h0014, 16'h0FFF);
      send_write(OP_WRITE_BAND, 16'h0015, 16'hFFFF);
      // state 4095: match word at the last address, header past the end
      send_write(OP_WRITE_ROW, 16'd4095, 16'hFFFE);
      send_write(OP_WRITE_BAND, 16'hFFFF, 16'hFFFF);
      // state 5: row at the last address, header past the end
      send_write(OP_WRITE_ROW, 16'd5, 16'hFFFF);
      // out of range indexes that alias the states above when truncated
      send_write(OP_WRITE_ROW, 16'h1000, 16'hFFFF);
      send_write(OP_WRITE_ROW, 16'hFFFF, 16'h0010);
      live_states.push_back(12'd0);
      live_states.push_back(12'd4095);
      live_states.push_back(12'd5);
      entry_slots.push_back(16'h0014);
      entry_slots.push_back(16'h0015);

      send_scan(8'h41, 1'b0);
      send_scan(8'h61, 1'b0);
      send_scan(8'h61, 1'b0);
      send_scan(8'h42, 1'b0);
      send_scan(8'h62, 1'b0);
      send_scan(8'h40, 1'b0);
      send_scan(8'h43, 1'b0);
      send_scan(8'hE1, 1'b0);
      send_scan(8'h61, 1'b1);
      send_write(OP_SET_STATE, 16'h0000, 16'h1FFF);
      send_scan(8'h41, 1'b0);
      send_write(OP_SET_STATE, 16'hFFFF, 16'd5);
      send_scan(8'hFF, 1'b1);
      send_write(OP_SET_STATE, 16'h1234, 16'd4095);
      send_scan(8'h41, 1'b0);
      send_write(OP_SET_STATE, 16'h0000, 16'hFFFF);
      send_scan(8'h41, 1'b1);
   endtask

   // position counts a run of bytes and restarts after the buffer end
   task automatic test_position_restart();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_write(OP_SET_STATE, 16'h0000, 16'h0000);
      for (int i = 0; i < RUN_LEN; i++) begin
         send_scan(8'h00, 1'b0);
      end
      send_scan(8'h41, 1'b0);
      send_scan(8'h61, 1'b0);
      send_scan(8'h41, 1'b1);
      send_scan(8'h61, 1'b0);
      send_scan(8'h41, 1'b0);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // random automata, the last one with no idling on either side
   task automatic test_random_scan();
      build_dfa(8, 4);
      random_traffic(120);
      build_dfa(6, 26);
      random_traffic(120);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      build_dfa(10, 6);
      random_traffic(120);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   // rsp side accepts at random
   always @(posedge clock) begin
      rsp_tready <= !rsp_idle_en || ($urandom_range(99) >= 34);
   end

   // compare each rsp transfer with the oldest expected match
   always @(posedge clock) begin : check_matches
      match_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.state    = rsp_tdata[11:0];
         got.position = rsp_tdata[28:12];
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual state %0d position %0d",
                     $time, got.state, got.position);
            mismatches++;
         end else begin
            want = expected_matches[0];
            expected_matches.delete(0);
            if (got.state != want.state) begin
               $display("%0t: match_state expected %0d actual %0d",
                        $time, want.state, got.state);
               mismatches++;
            end
            if (got.position != want.position) begin
               $display("%0t: end_position expected %0d actual %0d",
                        $time, want.position, got.position);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_lookup();
      test_position_restart();
      test_random_scan();
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== banded_dfa_pattern_scan_unit.f =====
hw/rtl/bdps_pkg.sv
hw/rtl/banded_dfa_pattern_scan_unit.sv
tb/testbench.sv
